/* rtl/mssc_pkg.sv */
`default_nettype none
package mssc_pkg;

  localparam int REG_COUNT   = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_ADDI = 3'd2;
  localparam logic [2:0] OP_LW   = 3'd3;
  localparam logic [2:0] OP_SW   = 3'd4;
  localparam logic [2:0] OP_BEQ  = 3'd5;
  localparam logic [2:0] OP_J    = 3'd6;

  localparam int F_REGDST   = 0;
  localparam int F_JUMP     = 1;
  localparam int F_BRANCH   = 2;
  localparam int F_MEMREAD  = 3;
  localparam int F_MEMTOREG = 4;
  localparam int F_MEMWRITE = 5;
  localparam int F_ALUSRC   = 6;
  localparam int F_REGWRITE = 7;
  localparam int F_ALUZERO  = 8;

  localparam logic [1:0] ALU_OP_ADD    = 2'd0;
  localparam logic [1:0] ALU_OP_BRANCH = 2'd1;
  localparam logic [1:0] ALU_OP_RTYPE  = 2'd2;

  localparam logic [3:0] ALU_CTL_NONE = 4'd0;
  localparam logic [3:0] ALU_CTL_ADD  = 4'd2;
  localparam logic [3:0] ALU_CTL_SUB  = 4'd6;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BAD_OP = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;

  typedef struct packed {
    logic [8:0] flags;
    logic [1:0] alu_op;
    logic [3:0] alu_ctl;
  } ctrl_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [4:0]  rd;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [31:0] imm;
    logic [31:0] br_off;
    logic [25:0] target;
    ctrl_t       ctrl;
  } entry_t;

  function automatic ctrl_t decode(input logic [2:0] op);
    ctrl_t c;
    c = '0;
    case (op)
      OP_ADD, OP_SUB: begin
        c.flags[F_REGDST]   = 1'b1;
        c.flags[F_REGWRITE] = 1'b1;
        c.alu_op            = ALU_OP_RTYPE;
        c.alu_ctl           = (op == OP_SUB) ? ALU_CTL_SUB : ALU_CTL_ADD;
      end
      OP_ADDI: begin
        c.flags[F_ALUSRC]   = 1'b1;
        c.flags[F_REGWRITE] = 1'b1;
        c.alu_op            = ALU_OP_ADD;
        c.alu_ctl           = ALU_CTL_ADD;
      end
      OP_LW: begin
        c.flags[F_MEMREAD]  = 1'b1;
        c.flags[F_MEMTOREG] = 1'b1;
        c.flags[F_ALUSRC]   = 1'b1;
        c.flags[F_REGWRITE] = 1'b1;
        c.alu_op            = ALU_OP_ADD;
        c.alu_ctl           = ALU_CTL_ADD;
      end
      OP_SW: begin
        c.flags[F_MEMWRITE] = 1'b1;
        c.flags[F_ALUSRC]   = 1'b1;
        c.alu_op            = ALU_OP_ADD;
        c.alu_ctl           = ALU_CTL_ADD;
      end
      OP_BEQ: begin
        c.flags[F_BRANCH] = 1'b1;
        c.alu_op          = ALU_OP_BRANCH;
        c.alu_ctl         = ALU_CTL_SUB;
      end
      OP_J: begin
        c.flags[F_JUMP] = 1'b1;
        c.alu_op        = ALU_OP_ADD;
        c.alu_ctl       = ALU_CTL_NONE;
      end
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

/* rtl/mssc_if.sv */
`default_nettype none
interface mssc_inst_if;
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic [4:0]         dest_reg;
  logic [4:0]         src_reg;
  logic [4:0]         second_reg;
  logic signed [15:0] immediate;
  logic [25:0]        jump_target;

  modport source (
    output valid, opcode, dest_reg, src_reg, second_reg, immediate, jump_target,
    input  ready
  );
  modport sink (
    input  valid, opcode, dest_reg, src_reg, second_reg, immediate, jump_target,
    output ready
  );
endinterface

interface mssc_res_if;
  logic               valid;
  logic               ready;
  logic [31:0]        pc_out;
  logic [8:0]         control_flags;
  logic [1:0]         alu_op;
  logic [3:0]         alu_func;
  logic signed [31:0] result_value;
  logic [1:0]         status;

  modport source (
    output valid, pc_out, control_flags, alu_op, alu_func, result_value, status,
    input  ready
  );
  modport sink (
    input  valid, pc_out, control_flags, alu_op, alu_func, result_value, status,
    output ready
  );
endinterface
`default_nettype wire

/* rtl/mssc_front.sv */
`default_nettype none
module mssc_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            hold,
  mssc_inst_if.sink       inst,
  output logic            q_valid,
  input  logic            q_ready,
  output mssc_pkg::entry_t q_entry
);

  localparam int PW = $clog2(mssc_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(mssc_pkg::QUEUE_DEPTH + 1);

  mssc_pkg::entry_t slots [mssc_pkg::QUEUE_DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             push;
  logic             pop;
  mssc_pkg::entry_t dec;

  // classify the beat and precompute the branch offset
  always_comb begin
    dec.op     = inst.opcode;
    dec.rd     = inst.dest_reg;
    dec.rs     = inst.src_reg;
    dec.rt     = inst.second_reg;
    dec.imm    = {{16{inst.immediate[15]}}, inst.immediate};
    dec.br_off = {{14{inst.immediate[15]}}, inst.immediate, 2'b00} + 32'd4;
    dec.target = inst.jump_target;
    dec.ctrl   = mssc_pkg::decode(inst.opcode);
  end

  assign inst.ready = !hold && (count != CW'(mssc_pkg::QUEUE_DEPTH));
  assign push       = inst.valid && inst.ready;
  assign q_valid    = (count != '0);
  assign pop        = q_valid && q_ready;
  assign q_entry    = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= dec;
    end
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(mssc_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (pop) begin
        rptr <= (rptr == PW'(mssc_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

endmodule
`default_nettype wire

/* rtl/mssc_back.sv */
`default_nettype none
module mssc_back #(
  parameter int MEM_WORDS = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  output logic             q_ready,
  input  mssc_pkg::entry_t q_entry,
  output logic             clearing,
  mssc_res_if.source       res
);

  localparam int AW = $clog2(MEM_WORDS);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;
  localparam logic [1:0] S_LOAD  = 2'd3;

  logic [1:0]       state;
  logic [AW-1:0]    clr_addr;
  mssc_pkg::entry_t cur;

  logic [31:0] rf [mssc_pkg::REG_COUNT];
  logic [mssc_pkg::REG_COUNT-1:0] rf_valid;
  logic [31:0] ra;
  logic [31:0] rb;
  logic        ra_ok;
  logic        rb_ok;

  logic [31:0] mem [MEM_WORDS];
  logic [31:0] mem_q;

  logic [31:0] pc;
  logic        out_valid;
  logic [8:0]  out_flags;
  logic [1:0]  out_alu_op;
  logic [3:0]  out_alu_ctl;
  logic [31:0] out_value;
  logic [1:0]  out_status;

  logic [31:0] a;
  logic [31:0] b;
  logic        is_sub;
  logic [31:0] addend;
  logic [31:0] alu_sum;
  logic [31:0] idx;
  logic        idx_ok;
  logic        out_free;
  logic        fin;
  logic        to_load;
  logic        rf_we;
  logic [4:0]  rf_wa;
  logic [31:0] rf_wd;
  logic        mem_we;
  logic [AW-1:0] mem_wa;
  logic [31:0] mem_wd;
  logic        mem_re;
  logic [8:0]  o_flags;
  logic [31:0] o_value;
  logic [1:0]  o_status;
  logic [31:0] pc_next;

  assign q_ready  = (state == S_IDLE);
  assign clearing = (state == S_CLEAR);
  assign out_free = !out_valid || res.ready;

  assign a       = ra_ok ? ra : '0;
  assign b       = rb_ok ? rb : '0;
  assign is_sub  = (cur.op == mssc_pkg::OP_SUB);
  assign addend  = is_sub ? ~b : ((cur.op == mssc_pkg::OP_ADDI) ? cur.imm : b);
  assign alu_sum = a + addend + {31'b0, is_sub};
  assign idx     = {cur.imm[29:0], 2'b00} + a;
  assign idx_ok  = !idx[31] && (idx < 32'(MEM_WORDS));

  always_comb begin
    fin      = 1'b0;
    to_load  = 1'b0;
    rf_we    = 1'b0;
    rf_wa    = cur.rd;
    rf_wd    = alu_sum;
    mem_we   = 1'b0;
    mem_wa   = idx[AW-1:0];
    mem_wd   = b;
    mem_re   = 1'b0;
    o_flags  = cur.ctrl.flags;
    o_value  = '0;
    o_status = mssc_pkg::ST_OK;
    pc_next  = pc + 32'd4;
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_addr;
        mem_wd = '0;
      end
      S_EXEC: begin
        case (cur.op)
          mssc_pkg::OP_ADD, mssc_pkg::OP_SUB: begin
            o_value = alu_sum;
            rf_we   = out_free;
          end
          mssc_pkg::OP_ADDI: begin
            o_value = alu_sum;
            rf_we   = out_free;
            rf_wa   = cur.rt;
          end
          mssc_pkg::OP_LW: begin
            if (idx_ok) begin
              to_load = 1'b1;
              mem_re  = 1'b1;
            end else begin
              o_status = mssc_pkg::ST_RANGE;
            end
          end
          mssc_pkg::OP_SW: begin
            if (idx_ok) begin
              o_value = b;
              mem_we  = out_free;
            end else begin
              o_status = mssc_pkg::ST_RANGE;
            end
          end
          mssc_pkg::OP_BEQ: begin
            if (a == b) begin
              o_flags[mssc_pkg::F_ALUZERO] = 1'b1;
              pc_next = pc + cur.br_off;
            end
          end
          mssc_pkg::OP_J: begin
            pc_next = {4'b0000, cur.target, 2'b00};
          end
          default: begin
            o_status = mssc_pkg::ST_BAD_OP;
            pc_next  = pc;
          end
        endcase
        fin = out_free && !to_load;
      end
      S_LOAD: begin
        o_value = mem_q;
        rf_we   = out_free;
        rf_wa   = cur.rt;
        rf_wd   = mem_q;
        fin     = out_free;
      end
      default: begin
        fin = 1'b0;
      end
    endcase
  end

  // register file: two registered reads at issue, one write at retire
  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf[rf_wa] <= rf_wd;
    end
    if (state == S_IDLE && q_valid) begin
      cur   <= q_entry;
      ra    <= rf[q_entry.rs];
      rb    <= rf[q_entry.rt];
      ra_ok <= rf_valid[q_entry.rs];
      rb_ok <= rf_valid[q_entry.rt];
    end
    if (rst) begin
      rf_valid <= '0;
    end else if (rf_we) begin
      rf_valid[rf_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_q <= mem[idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_flags   <= o_flags;
      out_alu_op  <= cur.ctrl.alu_op;
      out_alu_ctl <= cur.ctrl.alu_ctl;
      out_value   <= o_value;
      out_status  <= o_status;
    end
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      pc        <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(MEM_WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (to_load) begin
            state <= S_LOAD;
          end else if (fin) begin
            state <= S_IDLE;
          end
        end
        S_LOAD: begin
          if (fin) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (fin) begin
        out_valid <= 1'b1;
        pc        <= pc_next;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign res.valid         = out_valid;
  assign res.pc_out        = pc;
  assign res.control_flags = out_flags;
  assign res.alu_op        = out_alu_op;
  assign res.alu_func      = out_alu_ctl;
  assign res.result_value  = $signed(out_value);
  assign res.status        = out_status;

endmodule
`default_nettype wire

/* rtl/mips_subset_single_cycle_core_top.sv */
`default_nettype none
// channel  dir  payload                                               beat
// inst     in   opcode dest_reg src_reg second_reg immediate jump_target one instruction
// res      out  pc_out control_flags alu_op alu_func result_value      one result
//                status
//
// each instruction goes through register read and execute; an in-range lw also passes
// a load state for its data memory read port before writeback
// a two-entry decode queue takes new beats while the execute side works or waits
// after reset a clearing pass zeroes every data memory word, inst.ready low
// a stalled res holds the execute side; the queue keeps taking beats until full
module mips_subset_single_cycle_core_top #(
  parameter int MEM_WORDS = 1024
) (
  input  logic       clk,
  input  logic       rst,
  mssc_inst_if.sink  inst,
  mssc_res_if.source res
);

  logic             q_valid;
  logic             q_ready;
  logic             clearing;
  mssc_pkg::entry_t q_entry;

  mssc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .hold    (clearing),
    .inst    (inst),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_entry (q_entry)
  );

  mssc_back #(
    .MEM_WORDS (MEM_WORDS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_entry  (q_entry),
    .clearing (clearing),
    .res      (res)
  );

endmodule
`default_nettype wire

/* rtl/mssc_checker.sv */
`default_nettype none
module mssc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               res_valid,
  input logic               res_ready,
  input logic [31:0]        pc_out,
  input logic [8:0]         control_flags,
  input logic [1:0]         alu_op,
  input logic [3:0]         alu_func,
  input logic signed [31:0] result_value,
  input logic [1:0]         status
);

  // a stalled result beat holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(pc_out) && $stable(control_flags)
      && $stable(result_value) && $stable(status))
    else $error("result beat changed while stalled");

  // memory clearing starts right after reset, nothing in or out
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !in_ready && !res_valid)
    else $error("ports active right after reset");

  a_bad_op: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == mssc_pkg::ST_BAD_OP |-> control_flags == '0 && alu_op == '0
      && alu_func == '0 && result_value == '0)
    else $error("unknown opcode result not cleared");

  a_range: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == mssc_pkg::ST_RANGE |-> result_value == '0
      && !control_flags[mssc_pkg::F_ALUZERO]
      && (control_flags[mssc_pkg::F_MEMREAD] || control_flags[mssc_pkg::F_MEMWRITE]))
    else $error("out of range result malformed");

  a_jump: assert property (@(posedge clk) disable iff (rst)
    res_valid && control_flags[mssc_pkg::F_JUMP] |-> pc_out[1:0] == 2'b00
      && status == mssc_pkg::ST_OK && (in_valid || !in_valid))
    else $error("jump result malformed");

endmodule

bind mips_subset_single_cycle_core_top mssc_checker u_mssc_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (inst.valid),
  .in_ready      (inst.ready),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .pc_out        (res.pc_out),
  .control_flags (res.control_flags),
  .alu_op        (res.alu_op),
  .alu_func      (res.alu_func),
  .result_value  (res.result_value),
  .status        (res.status)
);
`default_nettype wire

/* tb/tb_mips_subset_single_cycle_core_top.sv */
`timescale 1ns / 100ps
module tb_mips_subset_single_cycle_core_top;

  localparam int MEM_WORDS = 1024;
  localparam logic [2:0] OP_BAD = 3'd7;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [2:0]  op;
    logic [4:0]  rd;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [15:0] imm;
    logic [25:0] target;
  } inst_t;

  typedef struct packed {
    logic [31:0] pc;
    logic [8:0]  flags;
    logic [1:0]  alu_op;
    logic [3:0]  alu_ctl;
    logic [31:0] value;
    logic [1:0]  status;
  } result_t;

  logic clk;
  logic rst;

  mssc_inst_if inst_bus ();
  mssc_res_if  res_bus ();

  mips_subset_single_cycle_core_top #(
    .MEM_WORDS(MEM_WORDS)
  ) dut (
    .clk (clk),
    .rst (rst),
    .inst(inst_bus),
    .res (res_bus)
  );

  logic [31:0] core_regs [mssc_pkg::REG_COUNT];
  logic [31:0] core_mem  [MEM_WORDS];
  logic [31:0] core_pc;
  result_t     pending_results [$];

  int  mismatches  = 0;
  int  items_sent  = 0;
  bit  quiet       = 1'b0;
  int  hold_req_n  = 0;
  int  hold_seen;
  int  rx_hold;
  int  rx_wait;
  int  rx_gap;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // architectural state after one instruction
  function automatic result_t exec_inst(input inst_t it);
    result_t     r;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] imm32;
    logic [31:0] idx;
    logic [31:0] nxt;
    bit          in_range;
    r        = '0;
    a        = core_regs[it.rs];
    b        = core_regs[it.rt];
    imm32    = {{16{it.imm[15]}}, it.imm};
    idx      = (imm32 << 2) + a;
    in_range = !idx[31] && (idx < MEM_WORDS);
    nxt      = core_pc + 32'd4;
    case (it.op)
      mssc_pkg::OP_ADD, mssc_pkg::OP_SUB: begin
        r.value = (it.op == mssc_pkg::OP_SUB) ? a - b : a + b;
        core_regs[it.rd] = r.value;
        r.flags[mssc_pkg::F_REGDST]   = 1'b1;
        r.flags[mssc_pkg::F_REGWRITE] = 1'b1;
        r.alu_op  = mssc_pkg::ALU_OP_RTYPE;
        r.alu_ctl = (it.op == mssc_pkg::OP_SUB) ? mssc_pkg::ALU_CTL_SUB : mssc_pkg::ALU_CTL_ADD;
      end
      mssc_pkg::OP_ADDI: begin
        r.value = a + imm32;
        core_regs[it.rt] = r.value;
        r.flags[mssc_pkg::F_ALUSRC]   = 1'b1;
        r.flags[mssc_pkg::F_REGWRITE] = 1'b1;
        r.alu_op  = mssc_pkg::ALU_OP_ADD;
        r.alu_ctl = mssc_pkg::ALU_CTL_ADD;
      end
      mssc_pkg::OP_LW: begin
        r.flags[mssc_pkg::F_MEMREAD]  = 1'b1;
        r.flags[mssc_pkg::F_MEMTOREG] = 1'b1;
        r.flags[mssc_pkg::F_ALUSRC]   = 1'b1;
        r.flags[mssc_pkg::F_REGWRITE] = 1'b1;
        r.alu_op  = mssc_pkg::ALU_OP_ADD;
        r.alu_ctl = mssc_pkg::ALU_CTL_ADD;
        if (in_range) begin
          r.value = core_mem[idx];
          core_regs[it.rt] = r.value;
        end else begin
          r.status = mssc_pkg::ST_RANGE;
        end
      end
      mssc_pkg::OP_SW: begin
        r.flags[mssc_pkg::F_MEMWRITE] = 1'b1;
        r.flags[mssc_pkg::F_ALUSRC]   = 1'b1;
        r.alu_op  = mssc_pkg::ALU_OP_ADD;
        r.alu_ctl = mssc_pkg::ALU_CTL_ADD;
        if (in_range) begin
          r.value = b;
          core_mem[idx] = b;
        end else begin
          r.status = mssc_pkg::ST_RANGE;
        end
      end
      mssc_pkg::OP_BEQ: begin
        r.flags[mssc_pkg::F_BRANCH] = 1'b1;
        r.alu_op  = mssc_pkg::ALU_OP_BRANCH;
        r.alu_ctl = mssc_pkg::ALU_CTL_SUB;
        if (a == b) begin
          r.flags[mssc_pkg::F_ALUZERO] = 1'b1;
          nxt = core_pc + 32'd4 + (imm32 << 2);
        end
      end
      mssc_pkg::OP_J: begin
        r.flags[mssc_pkg::F_JUMP] = 1'b1;
        r.alu_op  = mssc_pkg::ALU_OP_ADD;
        r.alu_ctl = mssc_pkg::ALU_CTL_NONE;
        nxt = {4'b0, it.target, 2'b00};
      end
      default: begin
        r.status = mssc_pkg::ST_BAD_OP;
        nxt = core_pc;
      end
    endcase
    core_pc = nxt;
    r.pc    = nxt;
    return r;
  endfunction

  function automatic inst_t mk(input logic [2:0] op, input int rd, input int rs,
                               input int rt, input int imm, input int target);
    inst_t it;
    it.op     = op;
    it.rd     = 5'(rd);
    it.rs     = 5'(rs);
    it.rt     = 5'(rt);
    it.imm    = 16'(imm);
    it.target = 26'(target);
    return it;
  endfunction

  function automatic inst_t rand_fields();
    inst_t it;
    it.op     = 3'($urandom_range(0, 7));
    it.rd     = 5'($urandom);
    it.rs     = 5'($urandom);
    it.rt     = 5'($urandom);
    it.imm    = 16'($urandom);
    it.target = 26'($urandom);
    return it;
  endfunction

  task automatic send_inst(input inst_t it);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      inst_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    inst_bus.valid       <= 1'b1;
    inst_bus.opcode      <= it.op;
    inst_bus.dest_reg    <= it.rd;
    inst_bus.src_reg     <= it.rs;
    inst_bus.second_reg  <= it.rt;
    inst_bus.immediate   <= it.imm;
    inst_bus.jump_target <= it.target;
    do @(posedge clk); while (!inst_bus.ready);
    pending_results.push_back(exec_inst(it));
    items_sent++;
  endtask

  task automatic drain_results();
    inst_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_alu_extremes();
    send_inst(mk(mssc_pkg::OP_ADDI, 0, 0, 1, 32767, 0));
    send_inst(mk(mssc_pkg::OP_ADDI, 0, 0, 2, -32768, 0));
    send_inst(mk(mssc_pkg::OP_ADD, 3, 1, 2, 0, 0));
    send_inst(mk(mssc_pkg::OP_SUB, 31, 0, 3, 0, 0));
    send_inst(mk(mssc_pkg::OP_ADD, 0, 3, 3, 0, 0));
    send_inst(mk(mssc_pkg::OP_SUB, 4, 2, 1, 0, 0));
    send_inst(mk(mssc_pkg::OP_ADD, 10, 31, 31, 0, 0));
  endtask

  task automatic test_memory_access();
    send_inst(mk(mssc_pkg::OP_SW, 0, 5, 3, 0, 0));
    send_inst(mk(mssc_pkg::OP_ADDI, 0, 5, 6, 3, 0));
    send_inst(mk(mssc_pkg::OP_SW, 0, 6, 4, 255, 0));
    send_inst(mk(mssc_pkg::OP_LW, 0, 6, 7, 255, 0));
    send_inst(mk(mssc_pkg::OP_LW, 0, 5, 8, 0, 0));
    send_inst(mk(mssc_pkg::OP_LW, 0, 5, 9, 100, 0));
    // index out of range: negative, one past the end, far above
    send_inst(mk(mssc_pkg::OP_LW, 0, 5, 11, -1, 0));
    send_inst(mk(mssc_pkg::OP_SW, 0, 5, 3, 256, 0));
    send_inst(mk(mssc_pkg::OP_LW, 0, 0, 12, 0, 0));
    send_inst(mk(mssc_pkg::OP_SW, 0, 1, 2, 32767, 0));
  endtask

  task automatic test_control_flow();
    send_inst(mk(mssc_pkg::OP_BEQ, 0, 3, 3, -32768, 0));
    send_inst(mk(mssc_pkg::OP_BEQ, 0, 1, 2, 32767, 0));
    send_inst(mk(mssc_pkg::OP_BEQ, 0, 5, 9, 32767, 0));
    send_inst(mk(mssc_pkg::OP_J, 0, 0, 0, 0, 26'h3FFFFFF));
    send_inst(mk(mssc_pkg::OP_J, 0, 0, 0, 0, 0));
    send_inst(mk(OP_BAD, 31, 31, 31, -1, 26'h3FFFFFF));
  endtask

  task automatic test_random_program();
    int    b;
    int    n;
    int    goal;
    inst_t it;
    goal = items_sent + 790;
    while (items_sent < goal) begin
      if ($urandom_range(0, 9) == 0) quiet = !quiet;
      if ($urandom_range(0, 149) == 0) drain_results();
      if ($urandom_range(0, 99) < 60) begin
        // zero a base register, offset it, then access memory around it, mixed with branches and random instructions
        b = $urandom_range(0, 31);
        send_inst(mk(mssc_pkg::OP_SUB, b, b, b, 0, 0));
        send_inst(mk(mssc_pkg::OP_ADDI, 0, b, b, $urandom_range(0, 1100), 0));
        n = $urandom_range(1, 6);
        repeat (n) begin
          it     = rand_fields();
          it.rs  = 5'(b);
          it.imm = 16'(int'($urandom_range(0, 300)) - 20);
          case ($urandom_range(0, 5))
            0, 1: it.op = mssc_pkg::OP_LW;
            2, 3: it.op = mssc_pkg::OP_SW;
            4: begin
              it.op = mssc_pkg::OP_BEQ;
              if ($urandom_range(0, 1)) it.rt = it.rs;
            end
            default: ;
          endcase
          send_inst(it);
        end
      end else begin
        it = rand_fields();
        if (it.op == mssc_pkg::OP_BEQ && $urandom_range(0, 1)) it.rt = it.rs;
        send_inst(it);
      end
    end
    quiet = 1'b0;
  endtask

  task automatic test_backpressure();
    drain_results();
    hold_req_n++;
    quiet = 1'b1;
    repeat (40) send_inst(rand_fields());
    quiet = 1'b0;
    drain_results();
  endtask

  // result sink with random stalls and a long hold on request
  always @(posedge clk) begin
    if (rst) begin
      res_bus.ready <= 1'b0;
      rx_wait       <= 0;
      rx_hold       <= 0;
      hold_seen     <= 0;
    end else if (hold_seen != hold_req_n) begin
      hold_seen     <= hold_req_n;
      rx_hold       <= HOLD_CYCLES;
      res_bus.ready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold       <= rx_hold - 1;
      res_bus.ready <= 1'b0;
    end else if (res_bus.ready && res_bus.valid) begin
      rx_gap = quiet ? 0 : $urandom_range(0, 19);
      if (rx_gap > 0) begin
        res_bus.ready <= 1'b0;
        rx_wait       <= rx_gap;
      end
    end else if (!res_bus.ready) begin
      if (rx_wait > 1) begin
        rx_wait <= rx_wait - 1;
      end else begin
        rx_wait       <= 0;
        res_bus.ready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t: %s mismatch expected %h actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // result beat check
  always @(posedge clk) begin
    result_t want;
    if (!rst && res_bus.valid && res_bus.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result expected none actual pc %h", $time, res_bus.pc_out);
      end else begin
        want = pending_results.pop_front();
        check_field("pc_out", want.pc, res_bus.pc_out);
        check_field("control_flags", 32'(want.flags), 32'(res_bus.control_flags));
        check_field("alu_op", 32'(want.alu_op), 32'(res_bus.alu_op));
        check_field("alu_func", 32'(want.alu_ctl), 32'(res_bus.alu_func));
        check_field("result_value", want.value, res_bus.result_value);
        check_field("status", 32'(want.status), 32'(res_bus.status));
      end
    end
  end

  initial begin
    for (int i = 0; i < mssc_pkg::REG_COUNT; i++) core_regs[i] = '0;
    for (int i = 0; i < MEM_WORDS; i++) core_mem[i] = '0;
    core_pc = '0;
    rst                  <= 1'b1;
    inst_bus.valid       <= 1'b0;
    inst_bus.opcode      <= '0;
    inst_bus.dest_reg    <= '0;
    inst_bus.src_reg     <= '0;
    inst_bus.second_reg  <= '0;
    inst_bus.immediate   <= '0;
    inst_bus.jump_target <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_alu_extremes();
    test_memory_access();
    test_control_flow();
    test_random_program();
    test_backpressure();

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
